// ===== hw/rtl/semantic_log_odds_update_assert.svh =====
// Assertion macros shared by the semantic log-odds update RTL.
`ifndef SEMANTIC_LOG_ODDS_UPDATE_ASSERT_SVH
`define SEMANTIC_LOG_ODDS_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SLOU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SLOU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SLOU_ASSERT(label, clk, rst_n, prop, msg)
`define SLOU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/slou_pkg.sv =====
// Types, constants and saturation helpers for the semantic log-odds update.
`timescale 1ns / 1ps
package slou_pkg;

  localparam int LO_W    = 16;
  localparam int COLOR_W = 24;
  localparam int WIDE_W  = 20;

  localparam logic [COLOR_W-1:0] EMPTY_COLOR = 24'hFFFFFF;
  localparam logic [WIDE_W-1:0]  LSE_SPAN    = 20'd2048;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_SEMANTIC = 2'd1,
    OP_FREE     = 2'd2,
    OP_PASS     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_MISS = 2'd0,
    REG_HIT  = 2'd1,
    REG_MAX  = 2'd2,
    REG_MIN  = 2'd3
  } reg_e;

  typedef logic signed [LO_W-1:0]   lo_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    lo_t                lo;
  } entry_t;

  // e^-(2^k / 256) in Q16
  localparam logic [15:0] EXP_Q16 [11] = '{
    16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
    16'd51039, 16'd39750, 16'd24109, 16'd8869,  16'd1200
  };

  function automatic lo_t sat16(input wide_t v);
    if (v > wide_t'(32767)) return 16'sh7FFF;
    if (v < wide_t'(-32768)) return 16'sh8000;
    return v[LO_W-1:0];
  endfunction

  function automatic lo_t clamp_lo(input wide_t v, input lo_t mn);
    if (v < wide_t'(mn)) return mn;
    return sat16(v);
  endfunction

  function automatic lo_t clamp_hi(input wide_t v, input lo_t mx);
    if (v > wide_t'(mx)) return mx;
    return sat16(v);
  endfunction

  function automatic lo_t clamp_both(input wide_t v, input lo_t mn, input lo_t mx);
    if (v < wide_t'(mn)) return mn;
    if (v > wide_t'(mx)) return mx;
    return sat16(v);
  endfunction

endpackage

// ===== hw/rtl/semantic_log_odds_update.sv =====
// Throughput: one record per cycle; four register stages (update, rank, permute and
// log-sum-exp difference, softplus lookup and clamp) all advance together and hold
// only while the output register is full and not taken.
// Reset: stage valid bits clear, configuration returns to phi -102, psi 218,
// max 896, min -512 (Q8.8). The softplus table is constant logic.
`timescale 1ns / 1ps
`include "semantic_log_odds_update_assert.svh"
module semantic_log_odds_update #(
  parameter int NUM_CLASSES          = 3,
  parameter int SOFTPLUS_TABLE_DEPTH = 256,
  localparam int InBits  = 58 + 40 * NUM_CLASSES,
  localparam int InW     = ((InBits + 7) / 8) * 8,
  localparam int OutBits = 16 + 40 * NUM_CLASSES,
  localparam int OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // operation, obs_color, prior_value, others_in, then per class: color, logodds
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // others_out, then per rank: top color, top logodds
  output logic [OutW-1:0] m_axis_tdata,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int NE   = NUM_CLASSES + 1;
  localparam int RW   = $clog2(NE);
  localparam int TIW  = (SOFTPLUS_TABLE_DEPTH > 1) ? $clog2(SOFTPLUS_TABLE_DEPTH) : 1;
  localparam int PW   = 11 + $clog2(SOFTPLUS_TABLE_DEPTH + 1);

  // ---- elaboration-time softplus table ----
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= dv) begin
        r = r - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] softplus_at(input int unsigned d);
    logic [63:0] t;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    t = 64'd65536;
    for (int k = 0; k < 11; k++) begin
      if (d[k]) t = (t * 64'(slou_pkg::EXP_Q16[k]) + 64'd32768) >> 16;
    end
    z = udiv64(t << 30, 64'd131072 + t);
    z2 = (z * z) >> 30;
    sum = z;
    p = z;
    for (int k = 3; k <= 11; k += 2) begin
      p = (p * z2) >> 30;
      sum = sum + udiv64(p, 64'(k));
    end
    sum = sum * 64'd2;
    return 16'((sum + 64'd2097152) >> 22);
  endfunction

  logic [7:0] sp_tab [SOFTPLUS_TABLE_DEPTH];
  for (genvar g = 0; g < SOFTPLUS_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [15:0] SpVal = softplus_at((g * 2048) / SOFTPLUS_TABLE_DEPTH);
    assign sp_tab[g] = SpVal[7:0];
  end

  // ---- configuration ----
  slou_pkg::lo_t miss_q, hit_q, max_q, min_q;
  slou_pkg::lo_t rd_val;
  logic          cfg_wr;
  slou_pkg::reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = slou_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= -16'sd102;
      hit_q  <= 16'sd218;
      max_q  <= 16'sd896;
      min_q  <= -16'sd512;
    end else if (cfg_wr) begin
      case (cfg_sel)
        slou_pkg::REG_MISS: miss_q <= pwdata[15:0];
        slou_pkg::REG_HIT:  hit_q  <= pwdata[15:0];
        slou_pkg::REG_MAX:  max_q  <= pwdata[15:0];
        slou_pkg::REG_MIN:  min_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      slou_pkg::REG_MISS: rd_val = miss_q;
      slou_pkg::REG_HIT:  rd_val = hit_q;
      slou_pkg::REG_MAX:  rd_val = max_q;
      slou_pkg::REG_MIN:  rd_val = min_q;
      default:            rd_val = miss_q;
    endcase
  end
  assign prdata = {{16{rd_val[15]}}, rd_val};

  // ---- pipeline control ----
  logic en;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= s_axis_tvalid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // ---- stage 1: per-entry update ----
  slou_pkg::op_e    in_op;
  logic [23:0]      in_obs;
  slou_pkg::lo_t    in_prior, in_oth;
  slou_pkg::entry_t in_ent [NUM_CLASSES];
  slou_pkg::entry_t s1_ent_d [NE];
  logic [NE-1:0]    s1_live_d;
  logic             s1_sort_d;
  slou_pkg::wide_t  s1_oth_d;
  logic             matched;

  assign in_op    = slou_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_obs   = s_axis_tdata[25:2];
  assign in_prior = $signed(s_axis_tdata[41:26]);
  assign in_oth   = $signed(s_axis_tdata[57:42]);
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_unpack
    assign in_ent[c].color = s_axis_tdata[58 + 40 * c +: 24];
    assign in_ent[c].lo    = $signed(s_axis_tdata[82 + 40 * c +: 16]);
  end

  always_comb begin
    matched = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if ((in_ent[i].color != slou_pkg::EMPTY_COLOR) && (in_ent[i].color == in_obs))
        matched = 1'b1;
    end
    s1_sort_d = (in_op == slou_pkg::OP_SEMANTIC) || (in_op == slou_pkg::OP_FREE);
    s1_live_d = {(in_op == slou_pkg::OP_SEMANTIC) && !matched, {NUM_CLASSES{1'b1}}};
    s1_ent_d[NUM_CLASSES].color = in_obs;
    s1_ent_d[NUM_CLASSES].lo =
      slou_pkg::sat16(slou_pkg::wide_t'(in_oth) + slou_pkg::wide_t'(hit_q));
    for (int i = 0; i < NUM_CLASSES; i++) begin
      s1_ent_d[i] = in_ent[i];
      case (in_op)
        slou_pkg::OP_INIT: begin
          if (i == 0) begin
            s1_ent_d[i].color = in_obs;
            s1_ent_d[i].lo = slou_pkg::clamp_both(
              slou_pkg::wide_t'(in_prior) + slou_pkg::wide_t'(hit_q), min_q, max_q);
          end else begin
            s1_ent_d[i].color = slou_pkg::EMPTY_COLOR;
            s1_ent_d[i].lo    = '0;
          end
        end
        slou_pkg::OP_SEMANTIC: begin
          // empty slots hold their value
          if (in_ent[i].color == slou_pkg::EMPTY_COLOR) begin
            s1_ent_d[i].lo = in_ent[i].lo;
          end else if (in_ent[i].color == in_obs) begin
            s1_ent_d[i].lo = slou_pkg::clamp_hi(
              slou_pkg::wide_t'(in_ent[i].lo) + slou_pkg::wide_t'(hit_q), max_q);
          end else begin
            s1_ent_d[i].lo = slou_pkg::clamp_lo(
              slou_pkg::wide_t'(in_ent[i].lo) + slou_pkg::wide_t'(miss_q), min_q);
          end
        end
        slou_pkg::OP_FREE: begin
          s1_ent_d[i].lo = slou_pkg::clamp_lo(
            slou_pkg::wide_t'(in_ent[i].lo) + slou_pkg::wide_t'(miss_q), min_q);
        end
        default: s1_ent_d[i] = in_ent[i];
      endcase
    end
    case (in_op)
      slou_pkg::OP_INIT: s1_oth_d = slou_pkg::wide_t'(slou_pkg::clamp_lo(
        slou_pkg::wide_t'(in_prior) + slou_pkg::wide_t'(miss_q), min_q));
      // raw sum; merge and clamp come later
      slou_pkg::OP_SEMANTIC: s1_oth_d = slou_pkg::wide_t'(in_oth) + slou_pkg::wide_t'(miss_q);
      slou_pkg::OP_FREE: s1_oth_d = slou_pkg::wide_t'(slou_pkg::clamp_lo(
        slou_pkg::wide_t'(in_oth) + slou_pkg::wide_t'(miss_q), min_q));
      default: s1_oth_d = slou_pkg::wide_t'(in_oth);
    endcase
  end

  slou_pkg::entry_t s1_ent_q [NE];
  logic [NE-1:0]    s1_live_q;
  logic             s1_sort_q;
  slou_pkg::wide_t  s1_oth_q;
  slou_pkg::op_e    s1_op_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ent_q  <= s1_ent_d;
      s1_live_q <= s1_live_d;
      s1_sort_q <= s1_sort_d;
      s1_oth_q  <= s1_oth_d;
      s1_op_q   <= in_op;
    end
  end

  // ---- stage 2: ranks ----
  slou_pkg::lo_t   s1_lo [NE];
  logic [RW-1:0]   rank_d [NE];

  for (genvar e = 0; e < NE; e++) begin : g_lo
    assign s1_lo[e] = s1_ent_q[e].lo;
  end

  slou_rank #(
    .NUM_ENTRIES(NE),
    .RANK_W     (RW)
  ) u_rank (
    .lo_i  (s1_lo),
    .live_i(s1_live_q),
    .sort_i(s1_sort_q),
    .rank_o(rank_d)
  );

  slou_pkg::entry_t s2_ent_q [NE];
  logic [RW-1:0]    s2_rank_q [NE];
  logic [NE-1:0]    s2_live_q;
  slou_pkg::wide_t  s2_oth_q;
  slou_pkg::op_e    s2_op_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ent_q  <= s1_ent_q;
      s2_rank_q <= rank_d;
      s2_live_q <= s1_live_q;
      s2_oth_q  <= s1_oth_q;
      s2_op_q   <= s1_op_q;
    end
  end

  // ---- stage 3: permute, pick the displaced entry ----
  logic [NE-1:0]    pick [NUM_CLASSES];
  slou_pkg::entry_t top_d [NUM_CLASSES];
  slou_pkg::lo_t    weak_lo;
  slou_pkg::wide_t  lse_a, lse_b, hi_d;
  logic [slou_pkg::WIDE_W-1:0] diff_d;

  always_comb begin
    weak_lo = '0;
    for (int p = 0; p < NUM_CLASSES; p++) begin
      top_d[p] = '0;
      for (int i = 0; i < NE; i++) begin
        pick[p][i] = s2_live_q[i] && (s2_rank_q[i] == RW'(p));
        if (pick[p][i]) top_d[p] = top_d[p] | s2_ent_q[i];
      end
    end
    for (int i = 0; i < NE; i++) begin
      if (s2_live_q[i] && (s2_rank_q[i] == RW'(NUM_CLASSES)))
        weak_lo = weak_lo | s2_ent_q[i].lo;
    end
    lse_a  = s2_oth_q;
    lse_b  = slou_pkg::wide_t'(weak_lo);
    hi_d   = (lse_a > lse_b) ? lse_a : lse_b;
    diff_d = (lse_a > lse_b) ? (lse_a - lse_b) : (lse_b - lse_a);
  end

  slou_pkg::entry_t s3_top_q [NUM_CLASSES];
  slou_pkg::wide_t  s3_oth_q, s3_hi_q;
  logic [slou_pkg::WIDE_W-1:0] s3_diff_q;
  logic             s3_lse_q;
  slou_pkg::op_e    s3_op_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_top_q  <= top_d;
      s3_oth_q  <= s2_oth_q;
      s3_hi_q   <= hi_d;
      s3_diff_q <= diff_d;
      s3_lse_q  <= s2_live_q[NUM_CLASSES];
      s3_op_q   <= s2_op_q;
    end
  end

  // ---- stage 4: softplus lookup, final clamp ----
  logic [PW-1:0]   idx_prod;
  logic [TIW-1:0]  sp_idx;
  slou_pkg::wide_t merged;
  slou_pkg::lo_t   oth_d;

  assign idx_prod = PW'(s3_diff_q[10:0]) * PW'(SOFTPLUS_TABLE_DEPTH);
  assign sp_idx   = TIW'(idx_prod >> 11);

  always_comb begin
    if (!s3_lse_q) begin
      merged = s3_oth_q;
    end else if (s3_diff_q < slou_pkg::LSE_SPAN) begin
      merged = s3_hi_q + slou_pkg::wide_t'({12'd0, sp_tab[sp_idx]});
    end else begin
      merged = s3_hi_q;
    end
    if (s3_op_q == slou_pkg::OP_SEMANTIC) oth_d = slou_pkg::clamp_both(merged, min_q, max_q);
    else oth_d = s3_oth_q[15:0];
  end

  slou_pkg::entry_t out_top_q [NUM_CLASSES];
  slou_pkg::lo_t    out_oth_q;
  slou_pkg::op_e    out_op_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_top_q <= s3_top_q;
      out_oth_q <= oth_d;
      out_op_q  <= s3_op_q;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[15:0] = out_oth_q;
    for (int p = 0; p < NUM_CLASSES; p++) begin
      m_axis_tdata[16 + 40 * p +: 24] = out_top_q[p].color;
      m_axis_tdata[40 + 40 * p +: 16] = out_top_q[p].lo;
    end
  end

  // ---- assertions ----
  for (genvar p = 0; p < NUM_CLASSES; p++) begin : g_chk_perm
    `SLOU_ASSERT_IMPL(a_rank_perm, clk_i, rst_ni, s2_valid_q, $onehot(pick[p]), "rank slot not filled exactly once")
  end

  for (genvar p = 0; p + 1 < NUM_CLASSES; p++) begin : g_chk_order
    `SLOU_ASSERT_IMPL(a_sorted, clk_i, rst_ni, out_valid_q && ((out_op_q == slou_pkg::OP_SEMANTIC) || (out_op_q == slou_pkg::OP_FREE)), out_top_q[p].lo >= out_top_q[p + 1].lo, "result entries out of order")
  end

  `SLOU_ASSERT_IMPL(a_others_clamp, clk_i, rst_ni, out_valid_q && (out_op_q == slou_pkg::OP_SEMANTIC) && (min_q <= max_q), (out_oth_q >= min_q) && (out_oth_q <= max_q), "others outside clamp range")

endmodule

// ===== hw/rtl/slou_rank.sv =====
// Stable descending rank of each live entry; identity order when sorting is off.
`timescale 1ns / 1ps
module slou_rank #(
  parameter int NUM_ENTRIES = 4,
  parameter int RANK_W      = 2
) (
  input  slou_pkg::lo_t      lo_i   [NUM_ENTRIES],
  input  logic [NUM_ENTRIES-1:0] live_i,
  input  logic               sort_i,
  output logic [RANK_W-1:0]  rank_o [NUM_ENTRIES]
);

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      logic [RANK_W-1:0] cnt;
      cnt = '0;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        // earlier entries win ties, later ones must be strictly larger
        if (live_i[j] && (j != i)) begin
          if ((j < i) ? (lo_i[j] >= lo_i[i]) : (lo_i[j] > lo_i[i])) begin
            cnt = cnt + RANK_W'(1);
          end
        end
      end
      rank_o[i] = sort_i ? cnt : RANK_W'(i);
    end
  end

endmodule

// ===== tb/semantic_log_odds_update_tb.sv =====
// Self-checking testbench for the semantic log-odds update block.
`timescale 1ns / 1ps
module semantic_log_odds_update_tb;

  localparam int IN_W  = 184;
  localparam int OUT_W = 136;
  localparam int NCLS  = 3;
  localparam int SP_DEPTH = 256;

  typedef struct {
    slou_pkg::op_e     op;
    logic [slou_pkg::COLOR_W-1:0] obs;
    slou_pkg::lo_t     prior;
    slou_pkg::lo_t     oth;
    slou_pkg::entry_t  cls [NCLS];
  } voxel_req_t;

  typedef struct {
    slou_pkg::lo_t     oth;
    slou_pkg::entry_t  top [NCLS];
  } voxel_rec_t;

  class voxel_scoreboard;
    int miss_inc, hit_inc, max_lo, min_lo;
    int sp_tab [SP_DEPTH];
    voxel_rec_t pending_q [$];
    int errors;

    function new();
      miss_inc = -102;
      hit_inc  = 218;
      max_lo   = 896;
      min_lo   = -512;
      errors   = 0;
      for (int i = 0; i < SP_DEPTH; i++) sp_tab[i] = softplus((i * 2048) / SP_DEPTH);
    endfunction

    function int softplus(int unsigned d);
      longint unsigned t, z, z2, p, sum;
      t = 65536;
      for (int k = 0; k < 11; k++)
        if (d[k]) t = (t * longint'(slou_pkg::EXP_Q16[k]) + 32768) >> 16;
      z = (t << 30) / (131072 + t);
      z2 = (z * z) >> 30;
      sum = z;
      p = z;
      for (int k = 3; k <= 11; k += 2) begin
        p = (p * z2) >> 30;
        sum += p / k;
      end
      sum = sum * 2;
      return int'((sum + (64'd1 << 21)) >> 22);
    endfunction

    function int sat(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int merge_lse(int a, int b);
      int hi, lo;
      int unsigned idx;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      idx = (int'(hi - lo) * SP_DEPTH) >> 11;
      if (idx >= SP_DEPTH) return hi;
      return hi + sp_tab[idx];
    endfunction

    function void set_reg(slou_pkg::reg_e r, int v);
      case (r)
        slou_pkg::REG_MISS: miss_inc = v;
        slou_pkg::REG_HIT:  hit_inc  = v;
        slou_pkg::REG_MAX:  max_lo   = v;
        slou_pkg::REG_MIN:  min_lo   = v;
        default: ;
      endcase
    endfunction

    function voxel_rec_t update_voxel(voxel_req_t x);
      voxel_rec_t r;
      int lv [NCLS+1];
      logic [slou_pkg::COLOR_W-1:0] cv [NCLS+1];
      int n, others, v, kl, j;
      logic [slou_pkg::COLOR_W-1:0] kc;
      bit matched;
      n = NCLS;
      matched = 0;
      others = int'(x.oth);
      for (int i = 0; i < NCLS; i++) begin
        cv[i] = x.cls[i].color;
        lv[i] = int'($signed(x.cls[i].lo));
      end
      case (x.op)
        slou_pkg::OP_INIT: begin
          v = int'(x.prior) + hit_inc;
          if (v < min_lo) v = min_lo;
          else if (v > max_lo) v = max_lo;
          cv[0] = x.obs;
          lv[0] = sat(v);
          for (int i = 1; i < NCLS; i++) begin
            cv[i] = slou_pkg::EMPTY_COLOR;
            lv[i] = 0;
          end
          others = int'(x.prior) + miss_inc;
          if (others < min_lo) others = min_lo;
          others = sat(others);
        end
        slou_pkg::OP_SEMANTIC: begin
          for (int i = 0; i < NCLS; i++) begin
            if (cv[i] != slou_pkg::EMPTY_COLOR) begin
              if (cv[i] == x.obs) begin
                matched = 1;
                v = lv[i] + hit_inc;
                if (v > max_lo) v = max_lo;
              end else begin
                v = lv[i] + miss_inc;
                if (v < min_lo) v = min_lo;
              end
              lv[i] = sat(v);
            end
          end
          others = int'(x.oth) + miss_inc;
          if (!matched) begin
            cv[NCLS] = x.obs;
            lv[NCLS] = sat(int'(x.oth) + hit_inc);
            n = NCLS + 1;
          end
        end
        slou_pkg::OP_FREE: begin
          for (int i = 0; i < NCLS; i++) begin
            v = lv[i] + miss_inc;
            if (v < min_lo) v = min_lo;
            lv[i] = sat(v);
          end
          others = int'(x.oth) + miss_inc;
          if (others < min_lo) others = min_lo;
          others = sat(others);
        end
        default: ;
      endcase
      // stable descending rank; the new entry sits last among ties
      if (x.op == slou_pkg::OP_SEMANTIC || x.op == slou_pkg::OP_FREE) begin
        for (int i = 1; i < n; i++) begin
          kl = lv[i];
          kc = cv[i];
          j = i;
          while (j > 0 && lv[j-1] < kl) begin
            lv[j] = lv[j-1];
            cv[j] = cv[j-1];
            j--;
          end
          lv[j] = kl;
          cv[j] = kc;
        end
      end
      if (x.op == slou_pkg::OP_SEMANTIC) begin
        if (n > NCLS) others = merge_lse(others, lv[NCLS]);
        if (others < min_lo) others = min_lo;
        else if (others > max_lo) others = max_lo;
        others = sat(others);
      end
      r.oth = slou_pkg::lo_t'(others);
      for (int i = 0; i < NCLS; i++) begin
        r.top[i].color = cv[i];
        r.top[i].lo = slou_pkg::lo_t'(lv[i]);
      end
      return r;
    endfunction

    function void note_request(logic [IN_W-1:0] d);
      voxel_req_t x;
      x.op    = slou_pkg::op_e'(d[1:0]);
      x.obs   = d[25:2];
      x.prior = d[41:26];
      x.oth   = d[57:42];
      for (int i = 0; i < NCLS; i++) begin
        x.cls[i].color = d[58+40*i +: 24];
        x.cls[i].lo    = d[82+40*i +: 16];
      end
      pending_q.insert(pending_q.size(), update_voxel(x));
    endfunction

    task report(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] d);
      voxel_rec_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      w = pending_q.pop_front();
      if (d[15:0] !== w.oth) report("others_out", d[15:0], w.oth);
      for (int i = 0; i < NCLS; i++) begin
        if (d[16+40*i +: 24] !== w.top[i].color)
          report($sformatf("top%0d_color", i), d[16+40*i +: 24], w.top[i].color);
        if (d[40+40*i +: 16] !== w.top[i].lo)
          report($sformatf("top%0d_logodds", i), d[40+40*i +: 16], w.top[i].lo);
      end
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;   // op, obs_color, prior, others_in, {color, logodds} x3
  logic [OUT_W-1:0] m_axis_tdata;  // others_out, {top color, top logodds} x3
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  voxel_scoreboard sb = new();
  int burst_left = 0;
  int cyc = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  semantic_log_odds_update i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: stall pattern steps through four settings, plus one long hold-off.
  always @(posedge clk_i) begin
    cyc++;
    if (hold_req && !hold_done) begin
      hold_left = 120;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((cyc / 64) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("semantic_log_odds_update_tb failed");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_req(voxel_req_t x);
    logic [IN_W-1:0] d;
    d = '0;
    d[1:0] = x.op;
    d[25:2] = x.obs;
    d[41:26] = x.prior;
    d[57:42] = x.oth;
    for (int i = 0; i < NCLS; i++) begin
      d[58+40*i +: 24] = x.cls[i].color;
      d[82+40*i +: 16] = x.cls[i].lo;
    end
    return d;
  endfunction

  function automatic voxel_req_t mk(slou_pkg::op_e op, logic [23:0] obs, int prior, int oth,
                                    logic [23:0] c0, int l0, logic [23:0] c1, int l1,
                                    logic [23:0] c2, int l2);
    voxel_req_t x;
    x.op = op;
    x.obs = obs;
    x.prior = slou_pkg::lo_t'(prior);
    x.oth = slou_pkg::lo_t'(oth);
    x.cls[0] = '{c0, slou_pkg::lo_t'(l0)};
    x.cls[1] = '{c1, slou_pkg::lo_t'(l1)};
    x.cls[2] = '{c2, slou_pkg::lo_t'(l2)};
    return x;
  endfunction

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 9))
      0: return slou_pkg::EMPTY_COLOR;
      1: return 24'($urandom);
      default: return 24'(24'h101010 * $urandom_range(1, 5));
    endcase
  endfunction

  function automatic slou_pkg::lo_t pick_lo();
    if ($urandom_range(0, 7) == 0) return slou_pkg::lo_t'($urandom);
    return slou_pkg::lo_t'(int'($urandom_range(0, 2400)) - 1200);
  endfunction

  function automatic voxel_req_t rand_req();
    voxel_req_t x;
    int r;
    r = $urandom_range(0, 19);
    x.op = (r < 3) ? slou_pkg::OP_INIT : (r < 15) ? slou_pkg::OP_SEMANTIC :
           (r < 19) ? slou_pkg::OP_FREE : slou_pkg::OP_PASS;
    x.obs = pick_color();
    x.prior = pick_lo();
    x.oth = pick_lo();
    for (int i = 0; i < NCLS; i++) x.cls[i] = '{pick_color(), pick_lo()};
    return x;
  endfunction

  task automatic send(voxel_req_t x);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_req(x);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(slou_pkg::reg_e r, int v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(r) << 2;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, int'(slou_pkg::lo_t'(v)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(int miss, int hit, int mx, int mn);
    drain();
    write_reg(slou_pkg::REG_MISS, miss);
    write_reg(slou_pkg::REG_HIT, hit);
    write_reg(slou_pkg::REG_MAX, mx);
    write_reg(slou_pkg::REG_MIN, mn);
  endtask

  localparam logic [23:0] RED = 24'hFF0000, GRN = 24'h00FF00, BLU = 24'h0000FF;
  localparam logic [23:0] YEL = 24'hFFFF00;

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration
    send(mk(slou_pkg::OP_INIT, RED, 0, 0, GRN, 5, BLU, 6, YEL, 7));
    send(mk(slou_pkg::OP_INIT, 24'h000000, 32767, -32768, 0, 0, 0, 0, 0, 0));
    send(mk(slou_pkg::OP_INIT, slou_pkg::EMPTY_COLOR, -32768, 32767, RED, 1, RED, 1, RED, 1));
    send(mk(slou_pkg::OP_SEMANTIC, RED, 0, 0, RED, 300, GRN, 200, BLU, 100));
    send(mk(slou_pkg::OP_SEMANTIC, GRN, 0, -200, RED, 300, GRN, 200, BLU, 100));
    send(mk(slou_pkg::OP_SEMANTIC, BLU, 0, -200, BLU, 100, GRN, 200, BLU, 150));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, 800, RED, 10, GRN, 20, BLU, 30));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, -900, RED, 10, GRN, 20, BLU, 30));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, -218, RED, 0, GRN, 0, BLU, 100));
    send(mk(slou_pkg::OP_SEMANTIC, RED, 0, 0, slou_pkg::EMPTY_COLOR, 50, RED, 0,
            slou_pkg::EMPTY_COLOR, -50));
    send(mk(slou_pkg::OP_SEMANTIC, slou_pkg::EMPTY_COLOR, 0, 0, slou_pkg::EMPTY_COLOR, 0,
            RED, 40, GRN, -40));
    send(mk(slou_pkg::OP_SEMANTIC, RED, 0, 0, RED, 890, GRN, -500, BLU, -512));
    send(mk(slou_pkg::OP_SEMANTIC, RED, 0, 32767, RED, 32767, GRN, -32768, BLU, 32767));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, -32768, RED, 32767, GRN, -32768, BLU, 0));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, 32767, RED, -32768, GRN, -32768, BLU, -32768));
    send(mk(slou_pkg::OP_SEMANTIC, YEL, 0, -300, RED, -120, GRN, -500, BLU, -510));
    send(mk(slou_pkg::OP_FREE, 0, 0, -32768, RED, -32768, GRN, 32767,
            slou_pkg::EMPTY_COLOR, 0));
    send(mk(slou_pkg::OP_FREE, 0, 0, 100, RED, 10, GRN, 300, BLU, 300));
    send(mk(slou_pkg::OP_PASS, 24'hFFFFFF, -1, -1, RED, -1, GRN, 32767, BLU, -32768));
    send(mk(slou_pkg::OP_PASS, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (200) send(rand_req());
    configure(-$urandom_range(0, 300), $urandom_range(0, 600),
              $urandom_range(200, 2000), -$urandom_range(0, 2000));
    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    repeat (150) send(rand_req());
    configure(-32768, 32767, 32767, -32768);
    repeat (150) send(rand_req());
    configure(32767, -32768, -500, 500);  // min above max
    repeat (150) send(rand_req());
    configure(int'(slou_pkg::lo_t'($urandom)), int'(slou_pkg::lo_t'($urandom)),
              int'(slou_pkg::lo_t'($urandom)), int'(slou_pkg::lo_t'($urandom)));
    repeat (150) send(rand_req());
    drain();

    if (sb.errors == 0) begin
      $display("semantic_log_odds_update_tb passed");
    end else begin
      $display("semantic_log_odds_update_tb failed");
    end
    $finish;
  end

endmodule
